>>> sv/gls_pkg.sv
// Shared types and constants of the grid line-of-sight block.
// Used by the front, the command queue, the back end and the top level.
package gls_pkg;

    localparam int COORD_W = 6;
    localparam int ACC_W   = 15;
    localparam int HALF_W  = 12;
    localparam int STEP_W  = 13;
    localparam int LIM_W   = 9;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SKIP,
        OP_SEEN,
        OP_WALK
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [COORD_W-1:0]         row;
        logic [COORD_W-1:0]         col;
        logic                       val;
        logic                       col_major;
        logic [COORD_W-1:0]         m_start;
        logic [COORD_W-1:0]         m_end;
        logic [COORD_W-1:0]         n_start;
        logic                       sm_neg;
        logic                       sn_neg;
        logic                       knight;
        logic signed [ACC_W-1:0]    acc;
        logic [HALF_W-1:0]          half;
        logic [STEP_W-1:0]          step;
        logic signed [ACC_W-1:0]    sub;
    } t_cmd;

endpackage

>>> sv/gls_front.sv
// Front end: accepts input words, classifies them and prepares walk set-up.
// Depends on gls_pkg; feeds gls_queue.
module gls_front #(
    parameter int MAP_ROWS = 64,
    parameter int MAP_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [gls_pkg::COORD_W-1:0]   i_from_row,
    input  logic [gls_pkg::COORD_W-1:0]   i_from_col,
    input  logic [gls_pkg::COORD_W-1:0]   i_to_row,
    input  logic [gls_pkg::COORD_W-1:0]   i_to_col,
    input  logic                          i_cell_clear,
    input  logic                          i_clearing,
    input  logic                          i_q_full,
    output logic                          o_push,
    output gls_pkg::t_cmd                 o_cmd
);

    localparam int CW = gls_pkg::COORD_W;
    localparam int LW = gls_pkg::LIM_W;
    localparam int AC = gls_pkg::ACC_W;
    localparam int HW = gls_pkg::HALF_W;
    localparam logic [LW-1:0] ROWS_LIM = LW'(MAP_ROWS);
    localparam logic [LW-1:0] COLS_LIM = LW'(MAP_COLS);

    typedef struct packed {
        gls_pkg::t_op     op;
        logic [CW-1:0]    row;
        logic [CW-1:0]    col;
        logic             val;
        logic             col_major;
        logic [CW-1:0]    m_first;
        logic [CW-1:0]    m_end;
        logic [CW-1:0]    n1;
        logic [CW-1:0]    n_first;
        logic             sm_neg;
        logic             sn_neg;
        logic             knight;
        logic             straight;
        logic             diag;
        logic [CW-1:0]    major_len;
        logic [CW-1:0]    minor_len;
    } t_pre;

    logic [CW:0]              dr;
    logic [CW:0]              dc;
    logic [CW-1:0]            ar;
    logic [CW-1:0]            ac;
    logic                     col_major;
    logic [CW-1:0]            m1;
    logic [CW-1:0]            n1;
    logic                     in_map;
    logic                     accept;
    t_pre                     n_pre;
    t_pre                     r_pre;
    logic                     r_a_valid;
    logic [HW-1:0]            sq;
    logic [HW-1:0]            prod;
    logic [gls_pkg::STEP_W-1:0] step;
    logic [gls_pkg::STEP_W-1:0] full;
    logic signed [AC-1:0]     sq_s;

    assign dr        = {1'b0, i_to_row} - {1'b0, i_from_row};
    assign dc        = {1'b0, i_to_col} - {1'b0, i_from_col};
    assign ar        = dr[CW] ? CW'((CW+1)'(0) - dr) : dr[CW-1:0];
    assign ac        = dc[CW] ? CW'((CW+1)'(0) - dc) : dc[CW-1:0];
    assign col_major = (ac >= ar);
    assign m1        = col_major ? i_from_col : i_from_row;
    assign n1        = col_major ? i_from_row : i_from_col;
    assign in_map    = (LW'(i_from_row) < ROWS_LIM) && (LW'(i_from_col) < COLS_LIM);

    always_comb begin
        n_pre.row       = i_from_row;
        n_pre.col       = i_from_col;
        n_pre.val       = i_cell_clear;
        n_pre.col_major = col_major;
        n_pre.sm_neg    = col_major ? dc[CW] : dr[CW];
        n_pre.sn_neg    = col_major ? dr[CW] : dc[CW];
        n_pre.m_first   = n_pre.sm_neg ? m1 - CW'(1) : m1 + CW'(1);
        n_pre.m_end     = col_major ? i_to_col : i_to_row;
        n_pre.n1        = n1;
        n_pre.n_first   = n_pre.sn_neg ? n1 - CW'(1) : n1 + CW'(1);
        n_pre.knight    = ((ar == CW'(2)) && (ac == CW'(1)))
                       || ((ar == CW'(1)) && (ac == CW'(2)));
        n_pre.straight  = (ar == '0) || (ac == '0);
        n_pre.diag      = (ar == ac);
        n_pre.major_len = col_major ? ac : ar;
        n_pre.minor_len = col_major ? ar : ac;
        priority if (i_kind == gls_pkg::KIND_WRITE) begin
            n_pre.op = in_map ? gls_pkg::OP_WRITE : gls_pkg::OP_SKIP;
        end else if ((ar < CW'(2)) && (ac < CW'(2))) begin
            n_pre.op = gls_pkg::OP_SEEN;
        end else begin
            n_pre.op = gls_pkg::OP_WALK;
        end
    end

    assign o_in_ready = !i_clearing && (!r_a_valid || !i_q_full);
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_a_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (o_push) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pre <= n_pre;
        end
    end

    assign sq   = HW'(r_pre.minor_len) * HW'(r_pre.minor_len);
    assign prod = HW'(r_pre.major_len) * HW'(r_pre.minor_len);
    assign step = {sq, 1'b0};
    assign full = {prod, 1'b0};
    assign sq_s = $signed(AC'(sq));

    always_comb begin
        o_cmd.op        = r_pre.op;
        o_cmd.row       = r_pre.row;
        o_cmd.col       = r_pre.col;
        o_cmd.val       = r_pre.val;
        o_cmd.col_major = r_pre.col_major;
        o_cmd.m_start   = r_pre.m_first;
        o_cmd.m_end     = r_pre.m_end;
        o_cmd.sm_neg    = r_pre.sm_neg;
        o_cmd.sn_neg    = r_pre.sn_neg;
        o_cmd.knight    = r_pre.knight;
        if (r_pre.straight) begin
            o_cmd.n_start = r_pre.n1;
            o_cmd.acc     = '0;
            o_cmd.half    = HW'(1);
            o_cmd.step    = '0;
            o_cmd.sub     = '0;
        end else begin
            o_cmd.n_start = r_pre.diag ? r_pre.n_first : r_pre.n1;
            o_cmd.acc     = r_pre.diag ? -sq_s : sq_s;
            o_cmd.half    = prod;
            o_cmd.step    = step;
            o_cmd.sub     = $signed(AC'(step)) - $signed(AC'(full));
        end
    end

endmodule

>>> sv/gls_queue.sv
// Short command queue between the front end and the back end.
// Depends on gls_pkg for the command type and depth.
module gls_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gls_pkg::t_cmd  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output gls_pkg::t_cmd  o_data
);

    localparam int QD = gls_pkg::Q_DEPTH;
    localparam int QA = gls_pkg::Q_AW;

    gls_pkg::t_cmd   r_slot [QD];
    logic [QA-1:0]   r_wr;
    logic [QA-1:0]   r_rd;
    logic [QA:0]     r_count;

    assign o_full  = (r_count == (QA+1)'(QD));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QA'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QA'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QA+1)'(1);
                2'b01:   r_count <= r_count - (QA+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("word popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QA+1)'(QD))
        else $error("queue holds more words than its depth");

endmodule

>>> sv/gls_back.sv
// Back end: holds the see-through map, performs writes and walks queries.
// Depends on gls_pkg; takes commands from gls_queue.
module gls_back #(
    parameter int MAP_ROWS = 64,
    parameter int MAP_COLS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  gls_pkg::t_cmd  i_head,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_visible
);

    localparam int CW    = gls_pkg::COORD_W;
    localparam int LW    = gls_pkg::LIM_W;
    localparam int AC    = gls_pkg::ACC_W;
    localparam int DEPTH = MAP_ROWS * MAP_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 7;
    localparam logic [LW-1:0] ROWS_LIM = LW'(MAP_ROWS);
    localparam logic [LW-1:0] COLS_LIM = LW'(MAP_COLS);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MAIN,
        B_EXTRA,
        B_DONE
    } t_state;

    t_state                    r_state;
    logic [AW-1:0]             r_clr_addr;
    logic                      r_pend;
    logic                      r_res;
    logic                      r_out_valid;
    logic                      r_out_vis;

    logic                      r_col_major;
    logic [CW-1:0]             r_m;
    logic [CW-1:0]             r_n;
    logic [CW-1:0]             r_m_end;
    logic                      r_sm_neg;
    logic                      r_sn_neg;
    logic                      r_knight;
    logic signed [AC-1:0]      r_acc;
    logic [gls_pkg::HALF_W-1:0] r_half;
    logic [gls_pkg::STEP_W-1:0] r_step;
    logic signed [AC-1:0]      r_sub;

    logic                      r_mem [DEPTH];
    logic                      r_rd_data;
    logic                      r_pend_oob;

    logic [CW-1:0]             rd_row;
    logic [CW-1:0]             rd_col;
    logic                      rd_oob;
    logic [PW-1:0]             rd_full;
    logic [AW-1:0]             rd_addr;
    logic [PW-1:0]             wr_full;
    logic                      mem_we;
    logic [AW-1:0]             mem_wa;
    logic                      mem_wd;
    logic                      check_ok;
    logic                      chk_end;
    logic                      at_end;
    logic                      issue;
    logic signed [AC-1:0]      acc_add;
    logic signed [AC-1:0]      acc_wrap;
    logic signed [AC-1:0]      half_s;
    logic                      go_over;
    logic                      on_half;
    logic [CW-1:0]             m_next;
    logic [CW-1:0]             n_next;
    logic                      out_free;
    logic                      load_walk;

    assign rd_row   = r_col_major ? r_n : r_m;
    assign rd_col   = r_col_major ? r_m : r_n;
    assign rd_oob   = (LW'(rd_row) >= ROWS_LIM) || (LW'(rd_col) >= COLS_LIM);
    assign rd_full  = PW'(rd_row) * PW'(MAP_COLS) + PW'(rd_col);
    assign rd_addr  = rd_oob ? '0 : rd_full[AW-1:0];
    assign wr_full  = PW'(i_head.row) * PW'(MAP_COLS) + PW'(i_head.col);

    assign check_ok = r_rd_data && !r_pend_oob;
    assign chk_end  = r_pend && (!check_ok || r_knight);
    assign at_end   = (r_m == r_m_end);
    assign issue    = !chk_end && (((r_state == B_MAIN) && !at_end) || (r_state == B_EXTRA));

    assign acc_add  = r_acc + $signed(AC'(r_step));
    assign acc_wrap = r_acc + r_sub;
    assign half_s   = $signed(AC'(r_half));
    assign go_over  = (acc_add > half_s);
    assign on_half  = (acc_add == half_s);
    assign m_next   = r_sm_neg ? r_m - CW'(1) : r_m + CW'(1);
    assign n_next   = r_sn_neg ? r_n - CW'(1) : r_n + CW'(1);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign load_walk  = o_pop && (i_head.op == gls_pkg::OP_WALK);
    assign o_clearing = (r_state == B_CLEAR);
    assign mem_we     = (r_state == B_CLEAR) || (o_pop && (i_head.op == gls_pkg::OP_WRITE));
    assign mem_wa     = (r_state == B_CLEAR) ? r_clr_addr : wr_full[AW-1:0];
    assign mem_wd     = (r_state == B_CLEAR) ? 1'b0 : i_head.val;

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_out_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_res       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_vis   <= 1'b0;
        end else begin
            r_pend <= issue;
            if (r_out_valid && i_out_ready && (r_state != B_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        unique case (i_head.op)
                            gls_pkg::OP_WRITE, gls_pkg::OP_SKIP: begin
                                r_state <= B_IDLE;
                            end
                            gls_pkg::OP_SEEN: begin
                                r_res   <= 1'b1;
                                r_state <= B_DONE;
                            end
                            gls_pkg::OP_WALK: begin
                                r_state <= B_MAIN;
                            end
                        endcase
                    end
                end
                B_MAIN: begin
                    priority if (chk_end) begin
                        r_res   <= check_ok;
                        r_state <= B_DONE;
                    end else if (at_end) begin
                        r_res   <= 1'b1;
                        r_state <= B_DONE;
                    end else if (go_over) begin
                        r_state <= B_EXTRA;
                    end
                end
                B_EXTRA: begin
                    if (chk_end) begin
                        r_res   <= check_ok;
                        r_state <= B_DONE;
                    end else begin
                        r_state <= B_MAIN;
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_vis   <= r_res;
                        r_state     <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (load_walk) begin
            r_col_major <= i_head.col_major;
            r_m         <= i_head.m_start;
            r_n         <= i_head.n_start;
            r_m_end     <= i_head.m_end;
            r_sm_neg    <= i_head.sm_neg;
            r_sn_neg    <= i_head.sn_neg;
            r_knight    <= i_head.knight;
            r_acc       <= i_head.acc;
            r_half      <= i_head.half;
            r_step      <= i_head.step;
            r_sub       <= i_head.sub;
        end else if ((r_state == B_MAIN) && !at_end) begin
            priority if (go_over) begin
                r_n   <= n_next;
                r_acc <= acc_wrap;
            end else if (on_half) begin
                r_n   <= n_next;
                r_acc <= acc_wrap;
                r_m   <= m_next;
            end else begin
                r_acc <= acc_add;
                r_m   <= m_next;
            end
        end else if (r_state == B_EXTRA) begin
            r_m <= m_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_pend_oob <= rd_oob;
    end

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == B_MAIN) || (r_state == B_EXTRA)))
        else $error("map read outstanding outside a walk");

    a_extra_after_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EXTRA) |-> ($past(r_state) == B_MAIN))
        else $error("corner cell read not preceded by a main step");

    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> (!r_out_valid && !r_pend && !o_pop))
        else $error("activity during the clearing pass");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == B_DONE))
        else $error("result word raised outside the done state");

endmodule

>>> sv/grid_line_of_sight.sv
// Top level of the grid line-of-sight block: front end, command queue, back end.
// Depends on gls_pkg, gls_front, gls_queue and gls_back.
//
// Channel  Direction  Handshake                  Word
// in       input      i_in_valid / o_in_ready    kind, rows, columns, cell_clear
// out      output     o_out_valid / i_out_ready  visible
//
// A write is stored in the map as it leaves the queue and gives no result word.
// A query walks the map cells on its line, paced by the single read port of the
// map memory, which reads one cell per cycle.
// After reset a clearing pass over all MAP_ROWS * MAP_COLS map cells runs with o_in_ready low.
// A four-word queue parts the two ends; a stalled output holds the back end in place
// while the front keeps accepting until the queue fills.
module grid_line_of_sight #(
    parameter int MAP_ROWS = 64,
    parameter int MAP_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [gls_pkg::COORD_W-1:0]   i_from_row,
    input  logic [gls_pkg::COORD_W-1:0]   i_from_col,
    input  logic [gls_pkg::COORD_W-1:0]   i_to_row,
    input  logic [gls_pkg::COORD_W-1:0]   i_to_col,
    input  logic                          i_cell_clear,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_visible
);

    logic           clearing;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    gls_pkg::t_cmd  push_cmd;
    gls_pkg::t_cmd  head_cmd;

    gls_front #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_from_row   (i_from_row),
        .i_from_col   (i_from_col),
        .i_to_row     (i_to_row),
        .i_to_col     (i_to_col),
        .i_cell_clear (i_cell_clear),
        .i_clearing   (clearing),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    gls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (head_cmd)
    );

    gls_back #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_visible   (o_visible)
    );

endmodule
